// ----- rtl/afl_pkg.sv -----
`timescale 1ns / 1ps

package afl_pkg;

  // Frame table size
  localparam int MAX_FRAMES = 64;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

  // Field widths
  localparam int DUR_W = 32;
  localparam int IMG_W = 32;
  localparam int TIM_W = 32;
  localparam int ST_W  = 2;

  // One table entry: duration in the low half, image id in the high half
  localparam int ENTRY_W = DUR_W + IMG_W;

  // Operation codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [ST_W-1:0] ST_DEFAULT = 2'd2;

endpackage

// ----- rtl/animation_frame_lookup_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Ports                          Contents
// in_       slave      in_tvalid/in_tready            one command item
// out_      master     out_tvalid/out_tready          one result item per command
// cfg_      write      cfg_wr_en/cfg_wr_data          default image id
//
// An append goes from accept through S_RESULT to the output register. A lookup
// with a nonzero total first takes the modulo on a restoring divider that retires
// one quotient bit a cycle, then the scan reads one table entry a cycle from the
// frame RAM, which has separate read and write ports. Items are taken one at a time.
// Synchronous active-low reset clears the frame count, the total and the
// default id; the frame RAM itself is not cleared. A result waits in the
// output register while out_tready is low; the next item is taken meanwhile.

module animation_frame_lookup_unit (
  input  logic        clk,
  input  logic        rst_n,
  // slave side
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // new_duration[31:0], new_image_id[63:32], lookup_time[95:64]
  input  logic        in_tuser,   // cmd[0]
  // master side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // image_id[31:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_RESULT = 3'd3;

  localparam int DW = afl_pkg::DUR_W;
  localparam int IW = afl_pkg::IMG_W;

  logic [2:0]                  state_r, state_nxt;
  logic [afl_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [DW-1:0]               total_r, total_nxt;
  logic [IW-1:0]               default_id_r;

  // divider
  logic [afl_pkg::TIM_W-1:0]   dvd_r, dvd_nxt;
  logic [DW-1:0]               rem_r, rem_nxt;
  logic [4:0]                  bit_r, bit_nxt;
  logic [DW:0]                 trial;
  logic [DW:0]                 trial_diff;

  // scan
  logic [afl_pkg::CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                        chk_v_r, chk_v_nxt;
  logic [DW:0]                 acc_r, acc_nxt;
  logic [DW:0]                 end_sum;
  logic                        rd_issue;

  // pending result
  logic [IW-1:0]               res_id_r, res_id_nxt;
  logic [afl_pkg::ST_W-1:0]    res_st_r, res_st_nxt;

  // output register
  logic                        out_v_r, out_v_nxt;
  logic [IW-1:0]               out_id_r, out_id_nxt;
  logic [afl_pkg::ST_W-1:0]    out_st_r, out_st_nxt;

  // RAM
  logic                        ram_we;
  logic [afl_pkg::IDX_W-1:0]   ram_waddr;
  logic [afl_pkg::ENTRY_W-1:0] ram_wdata;
  logic [afl_pkg::ENTRY_W-1:0] ram_rdata;

  logic                        in_acc;
  logic [DW:0]                 add_sum;
  logic [DW-1:0]               in_dur;
  logic [IW-1:0]               in_img;
  logic [afl_pkg::TIM_W-1:0]   in_time;

  assign in_dur  = in_tdata[DW-1:0];
  assign in_img  = in_tdata[DW+IW-1:DW];
  assign in_time = in_tdata[DW+IW+afl_pkg::TIM_W-1:DW+IW];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign add_sum   = {1'b0, total_r} + {1'b0, in_dur};

  assign trial      = {rem_r, dvd_r[afl_pkg::TIM_W-1]};
  assign trial_diff = trial - {1'b0, total_r};

  assign rd_issue = (state_r == S_SCAN) && (rd_idx_r < count_r);
  assign end_sum  = acc_r + {1'b0, ram_rdata[DW-1:0]};

  assign ram_waddr = count_r[afl_pkg::IDX_W-1:0];
  assign ram_wdata = {in_img, in_dur};

  afl_ram #(
    .WIDTH(afl_pkg::ENTRY_W),
    .DEPTH(afl_pkg::MAX_FRAMES)
  ) u_frames (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_issue),
    .raddr(rd_idx_r[afl_pkg::IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  // Sequencer: decode, divide, scan, hand off result
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    bit_nxt    = bit_r;
    rd_idx_nxt = rd_idx_r;
    chk_v_nxt  = 1'b0;
    acc_nxt    = acc_r;
    res_id_nxt = res_id_r;
    res_st_nxt = res_st_r;
    ram_we     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RESULT;
          if (in_tuser == afl_pkg::CMD_APPEND) begin
            res_id_nxt = '0;
            if (count_r == afl_pkg::CNT_W'(afl_pkg::MAX_FRAMES) || add_sum[DW]) begin
              res_st_nxt = afl_pkg::ST_REFUSED;
            end else begin
              res_st_nxt = afl_pkg::ST_OK;
              ram_we     = 1'b1;
              count_nxt  = count_r + 1'b1;
              total_nxt  = add_sum[DW-1:0];
            end
          end else if (total_r == '0) begin
            res_id_nxt = default_id_r;
            res_st_nxt = afl_pkg::ST_DEFAULT;
          end else begin
            state_nxt = S_DIV;
            dvd_nxt   = in_time;
            rem_nxt   = '0;
            bit_nxt   = '0;
          end
        end
      end
      S_DIV: begin
        // one restoring step per cycle
        if (trial >= {1'b0, total_r}) begin
          rem_nxt = trial_diff[DW-1:0];
        end else begin
          rem_nxt = trial[DW-1:0];
        end
        dvd_nxt = {dvd_r[afl_pkg::TIM_W-2:0], 1'b0};
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 5'd31) begin
          state_nxt  = S_SCAN;
          rd_idx_nxt = '0;
          acc_nxt    = '0;
        end
      end
      S_SCAN: begin
        // issue next read, check the entry that arrived
        if (rd_issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          chk_v_nxt  = 1'b1;
        end
        if (chk_v_r) begin
          acc_nxt = end_sum;
          if ({1'b0, rem_r} < end_sum) begin
            state_nxt  = S_RESULT;
            res_id_nxt = ram_rdata[afl_pkg::ENTRY_W-1:DW];
            res_st_nxt = afl_pkg::ST_OK;
            chk_v_nxt  = 1'b0;
          end
        end else if (!rd_issue) begin
          // ran off the end of the table
          state_nxt  = S_RESULT;
          res_id_nxt = default_id_r;
          res_st_nxt = afl_pkg::ST_DEFAULT;
        end
      end
      S_RESULT: begin
        if (!out_v_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load from the pending result, drop on handshake
  always_comb begin
    out_v_nxt  = out_v_r;
    out_id_nxt = out_id_r;
    out_st_nxt = out_st_r;
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (state_r == S_RESULT && (!out_v_r || out_tready)) begin
      out_v_nxt  = 1'b1;
      out_id_nxt = res_id_r;
      out_st_nxt = res_st_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      total_r      <= '0;
      default_id_r <= '0;
      chk_v_r      <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      chk_v_r <= chk_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_wr_en) begin
        default_id_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    bit_r    <= bit_nxt;
    rd_idx_r <= rd_idx_nxt;
    acc_r    <= acc_nxt;
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
    out_id_r <= out_id_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_st_r;

endmodule

// ----- rtl/afl_ram.sv -----
`timescale 1ns / 1ps

module afl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
